// File: hdl/escape_sequence_decoder_unit_macros.svh
// Assertion helpers
`ifndef ESCAPE_SEQUENCE_DECODER_UNIT_MACROS_SVH
`define ESCAPE_SEQUENCE_DECODER_UNIT_MACROS_SVH

// same-cycle implication
`define ESD_ASSERT_IMP(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("esd check failed");

// next-cycle implication
`define ESD_ASSERT_NXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("esd check failed");

`endif

// File: hdl/esd_pkg.sv
`default_nettype none
package esd_pkg;

  localparam int LENGTH_BITS = 16;

  typedef enum logic [2:0] {
    M_IDLE = 3'd0,
    M_ESC  = 3'd1,
    M_HEX1 = 3'd2,
    M_HEX2 = 3'd3,
    M_OCT1 = 3'd4,
    M_OCT2 = 3'd5,
    M_DROP = 3'd6
  } mode_t;

  localparam logic [2:0] ST_BYTE    = 3'd0;
  localparam logic [2:0] ST_DONE    = 3'd1;
  localparam logic [2:0] ST_END     = 3'd2;
  localparam logic [2:0] ST_NONHEX  = 3'd3;
  localparam logic [2:0] ST_UNKNOWN = 3'd4;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_BSL = 8'h5c;
  localparam logic [7:0] CH_X   = 8'h78;

  typedef struct packed {
    logic [7:0]  byte_out;
    logic [2:0]  status;
    logic [15:0] out_length;
    logic        last;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] val;
  } lookup_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic lookup_t hex_value(input logic [7:0] c);
    lookup_t r;
    r.ok  = 1'b1;
    r.val = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.val = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.val = c - 8'h57;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.val = c - 8'h37;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  function automatic lookup_t simple_escape(input logic [7:0] c);
    lookup_t r;
    r.ok = 1'b1;
    case (c)
      8'h65:   r.val = 8'h1b; // e
      8'h5c:   r.val = 8'h5c; // backslash
      8'h72:   r.val = 8'h0d; // r
      8'h6e:   r.val = 8'h0a; // n
      8'h61:   r.val = 8'h07; // a
      8'h62:   r.val = 8'h08; // b
      8'h74:   r.val = 8'h09; // t
      8'h76:   r.val = 8'h0b; // v
      8'h66:   r.val = 8'h0c; // f
      default: begin
        r.ok  = 1'b0;
        r.val = 8'h00;
      end
    endcase
    return r;
  endfunction

  function automatic logic octal_digit(input logic [7:0] c);
    return c[7:3] == 5'b00110;
  endfunction

  function automatic logic [LENGTH_BITS-1:0] sat_inc(input logic [LENGTH_BITS-1:0] v);
    return (&v) ? v : v + LENGTH_BITS'(1);
  endfunction

endpackage
`default_nettype wire

// File: hdl/esd_decode.sv
`default_nettype none
module esd_decode
  import esd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       fire,
  input  wire logic [7:0] char_in,
  output push_t           push
);

  mode_t                  mode, mode_next;
  logic [7:0]             first_hex_char, first_hex_char_next;
  logic [7:0]             octal_value, octal_value_next;
  logic [LENGTH_BITS-1:0] emitted_count, emitted_count_next;

  result_t    res [2];
  logic [1:0] n;
  logic       do_plain;
  lookup_t    se, hx_hi, hx_lo;

  always_comb begin
    mode_next           = mode;
    first_hex_char_next = first_hex_char;
    octal_value_next    = octal_value;
    emitted_count_next  = emitted_count;
    res[0]              = '0;
    res[1]              = '0;
    n                   = 2'd0;
    do_plain            = 1'b0;
    se                  = simple_escape(char_in);
    hx_hi               = hex_value(first_hex_char);
    hx_lo               = hex_value(char_in);

    case (mode)
      M_DROP: begin
        if (char_in == CH_NUL) begin
          mode_next          = M_IDLE;
          emitted_count_next = '0;
        end
      end
      M_ESC: begin
        if (char_in == CH_NUL) begin
          res[0].status      = ST_UNKNOWN;
          n                  = 2'd1;
          mode_next          = M_IDLE;
          emitted_count_next = '0;
        end else if (se.ok) begin
          res[0].byte_out    = se.val;
          n                  = 2'd1;
          emitted_count_next = sat_inc(emitted_count);
          mode_next          = M_IDLE;
        end else if (char_in == CH_X) begin
          mode_next = M_HEX1;
        end else if (octal_digit(char_in)) begin
          octal_value_next = {5'b0, char_in[2:0]};
          mode_next        = M_OCT1;
        end else begin
          res[0].status = ST_UNKNOWN;
          n             = 2'd1;
          mode_next     = M_DROP;
        end
      end
      M_HEX1: begin
        if (char_in == CH_NUL) begin
          res[0].status      = ST_END;
          n                  = 2'd1;
          mode_next          = M_IDLE;
          emitted_count_next = '0;
        end else begin
          first_hex_char_next = char_in;
          mode_next           = M_HEX2;
        end
      end
      M_HEX2: begin
        if (char_in == CH_NUL) begin
          res[0].status      = ST_END;
          n                  = 2'd1;
          mode_next          = M_IDLE;
          emitted_count_next = '0;
        end else if (hx_hi.ok && hx_lo.ok) begin
          res[0].byte_out    = {hx_hi.val[3:0], hx_lo.val[3:0]};
          n                  = 2'd1;
          emitted_count_next = sat_inc(emitted_count);
          mode_next          = M_IDLE;
        end else begin
          res[0].status = ST_NONHEX;
          n             = 2'd1;
          mode_next     = M_DROP;
        end
      end
      M_OCT1: begin
        if (octal_digit(char_in)) begin
          octal_value_next = {octal_value[4:0], char_in[2:0]};
          mode_next        = M_OCT2;
        end else begin
          res[0].byte_out    = octal_value;
          n                  = 2'd1;
          emitted_count_next = sat_inc(emitted_count);
          do_plain           = 1'b1;
        end
      end
      M_OCT2: begin
        if (octal_digit(char_in)) begin
          res[0].byte_out    = {octal_value[4:0], char_in[2:0]};
          n                  = 2'd1;
          emitted_count_next = sat_inc(emitted_count);
          mode_next          = M_IDLE;
        end else begin
          res[0].byte_out    = octal_value;
          n                  = 2'd1;
          emitted_count_next = sat_inc(emitted_count);
          do_plain           = 1'b1;
        end
      end
      default: do_plain = 1'b1;
    endcase

    // ordinary byte handling, possibly after a short octal escape
    if (do_plain) begin
      mode_next = M_IDLE;
      if (char_in == CH_NUL) begin
        res[n[0]].status     = ST_DONE;
        res[n[0]].out_length = 16'(emitted_count_next);
        n                    = n + 2'd1;
        emitted_count_next   = '0;
      end else if (char_in == CH_BSL) begin
        mode_next = M_ESC;
      end else begin
        res[n[0]].byte_out = char_in;
        n                  = n + 2'd1;
        emitted_count_next = sat_inc(emitted_count_next);
      end
    end

    if (n == 2'd1) res[0].last = 1'b1;
    if (n == 2'd2) res[1].last = 1'b1;

    push.count = fire ? n : 2'd0;
    push.r0    = res[0];
    push.r1    = res[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= M_IDLE;
      first_hex_char <= '0;
      octal_value    <= '0;
      emitted_count  <= '0;
    end else if (fire) begin
      mode           <= mode_next;
      first_hex_char <= first_hex_char_next;
      octal_value    <= octal_value_next;
      emitted_count  <= emitted_count_next;
    end
  end

endmodule
`default_nettype wire

// File: hdl/esd_out_fifo.sv
`default_nettype none
module esd_out_fifo
  import esd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  push_t     push,
  output logic      room2,
  output logic      out_valid,
  input  wire logic out_ready,
  output result_t   q
);

  result_t    entries [4];
  logic [1:0] wp, rp;
  logic [2:0] count;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = count != 3'd0;
  assign room2     = count <= 3'd2;
  assign q         = entries[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + push.count;
      rp    <= rp + {1'b0, pop};
      count <= count + {1'b0, push.count} - {2'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) entries[wp] <= push.r0;
    if (push.count == 2'd2) entries[wp + 2'd1] <= push.r1;
  end

endmodule
`default_nettype wire

// File: hdl/escape_sequence_decoder_unit.sv
// Escape sequence decoder: one text byte per request, up to two results per byte.
// A taken byte is registered, decoded, written to the result queue and offered from its head.
// Accepts one byte per cycle while the four-entry result queue has room for two;
//   bytes giving two results drain at the output rate of one result per cycle while out_ready is high.
// Reset (rst, synchronous): decoder idle, counters and queue cleared.
`default_nettype none
module escape_sequence_decoder_unit
  import esd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  char_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       byte_out,
  output logic [2:0]       status,
  output logic [15:0]      out_length,
  output logic             last
);

  logic       s1_valid;
  logic [7:0] s1_char;
  logic       room2;
  logic       fire;
  push_t      push;
  result_t    q;

  assign fire     = s1_valid && room2;
  assign in_ready = !s1_valid || room2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_char <= char_in;
  end

  esd_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .char_in (s1_char),
    .push    (push)
  );

  esd_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room2     (room2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .q         (q)
  );

  assign byte_out   = q.byte_out;
  assign status     = q.status;
  assign out_length = q.out_length;
  assign last       = q.last;

endmodule
`default_nettype wire

// File: hdl/esd_checker.sv
`default_nettype none
`include "escape_sequence_decoder_unit_macros.svh"
module esd_checker
  import esd_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [7:0]  byte_out,
  input wire logic [2:0]  status,
  input wire logic [15:0] out_length,
  input wire logic        last
);

  `ESD_ASSERT_IMP(a_status_range, out_valid, status <= ST_UNKNOWN)
  `ESD_ASSERT_IMP(a_byte_only_data, out_valid && status != ST_BYTE, byte_out == 8'h00)
  `ESD_ASSERT_IMP(a_len_only_done, out_valid && status != ST_DONE, out_length == 16'h0000)
  `ESD_ASSERT_IMP(a_end_is_last, out_valid && status != ST_BYTE, last)
  `ESD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status))

endmodule

bind escape_sequence_decoder_unit esd_checker u_esd_checker (.*);
`default_nettype wire
